@@ rtl/core/sfe_pkg.sv @@
package sfe_pkg;

   localparam int unsigned VALUE_BITS = 11;
   localparam int unsigned ACC_BITS   = 18;
   localparam int unsigned PEND_BITS  = 5;
   localparam int unsigned DCNT_BITS  = 5;
   localparam int unsigned Q_DEPTH    = 2;
   localparam int unsigned Q_PTR_BITS = 1;
   localparam int unsigned Q_CNT_BITS = 2;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX  = 11'h7ff;
   localparam logic [7:0]            START_BYTE = 8'h0f;
   localparam logic [7:0]            FLAGS_BYTE = 8'h00;
   localparam logic [DCNT_BITS-1:0]  DATA_BYTES = 5'd22;
   localparam logic [PEND_BITS-1:0]  BYTE_BITS  = 5'd8;

   typedef struct packed {
      logic [15:0] channel_value;
      logic        last_channel;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic                  start;
      logic                  take;
      logic                  last;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   typedef enum logic [4:0] {
      ST_RUN   = 5'b00001,
      ST_START = 5'b00010,
      ST_FILL  = 5'b00100,
      ST_FLAGS = 5'b01000,
      ST_END   = 5'b10000
   } back_state_type;

endpackage

@@ rtl/core/sfe_front.sv @@
module sfe_front #(
   parameter int unsigned CHANNEL_COUNT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sfe_pkg::req_type  req_payload,
   output logic              push,
   output sfe_pkg::entry_type push_entry,
   input  logic              q_full
);
   import sfe_pkg::*;

   logic                 frame_open_ff, frame_open_in;
   logic [4:0]           chan_ff, chan_in;
   logic                 accept;
   logic                 take;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign take      = chan_ff < 5'(CHANNEL_COUNT);

   always_comb begin
      push_entry.start = !frame_open_ff;
      push_entry.take  = take;
      push_entry.last  = req_payload.last_channel;
      // clamp to eleven bits
      push_entry.value = (|req_payload.channel_value[15:VALUE_BITS]) ? VALUE_MAX
                         : req_payload.channel_value[VALUE_BITS-1:0];
   end

   assign push = accept;

   always_comb begin
      frame_open_in = frame_open_ff;
      chan_in       = chan_ff;
      if (accept) begin
         if (req_payload.last_channel) begin
            frame_open_in = 1'b0;
            chan_in       = '0;
         end else begin
            frame_open_in = 1'b1;
            chan_in       = chan_ff + 5'(take);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         chan_ff       <= '0;
      end else begin
         frame_open_ff <= frame_open_in;
         chan_ff       <= chan_in;
      end
   end

endmodule

@@ rtl/core/sfe_queue.sv @@
module sfe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfe_pkg::entry_type push_entry,
   output logic               q_full,
   input  logic               pop,
   output logic               q_valid,
   output sfe_pkg::entry_type q_entry
);
   import sfe_pkg::*;

   entry_type               slot_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]   count_ff, count_in;

   assign q_full  = count_ff == Q_CNT_BITS'(Q_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/sfe_back.sv @@
module sfe_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  sfe_pkg::entry_type q_entry,
   output logic               pop,
   input  logic [7:0]         end_marker,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sfe_pkg::rsp_type   rsp_payload
);
   import sfe_pkg::*;

   back_state_type        state_ff, state_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in, acc_s;
   logic [PEND_BITS-1:0]  pend_ff, pend_in, pend_s;
   logic [DCNT_BITS-1:0]  dcnt_ff, dcnt_in;
   logic                  last_due_ff, last_due_in;
   entry_type             cur_ff, cur_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;
   logic                  out_free;
   logic                  emit;
   logic [7:0]            emit_byte;
   logic                  emit_eof;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      pend_in     = pend_ff;
      dcnt_in     = dcnt_ff;
      last_due_in = last_due_ff;
      cur_in      = cur_ff;
      acc_s       = acc_ff;
      pend_s      = pend_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      emit_byte   = '0;
      emit_eof    = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (pend_ff >= BYTE_BITS && out_free) begin
               emit      = 1'b1;
               emit_byte = acc_ff[7:0];
               acc_s     = acc_ff >> 8;
               pend_s    = pend_ff - BYTE_BITS;
               dcnt_in   = dcnt_ff + 1'b1;
            end
            acc_in  = acc_s;
            pend_in = pend_s;
            // whole bytes drained: close the frame or take the next request
            if (pend_s < BYTE_BITS) begin
               if (last_due_ff) begin
                  state_in = ST_FILL;
               end else if (q_valid) begin
                  pop         = 1'b1;
                  cur_in      = q_entry;
                  last_due_in = q_entry.last;
                  if (q_entry.start) begin
                     state_in = ST_START;
                  end else if (q_entry.take) begin
                     acc_in  = acc_s | (ACC_BITS'(q_entry.value) << pend_s[2:0]);
                     pend_in = pend_s + PEND_BITS'(VALUE_BITS);
                  end
               end
            end
         end
         ST_START: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = START_BYTE;
               state_in  = ST_RUN;
               if (cur_ff.take) begin
                  acc_in  = acc_ff | (ACC_BITS'(cur_ff.value) << pend_ff[2:0]);
                  pend_in = pend_ff + PEND_BITS'(VALUE_BITS);
               end
            end
         end
         ST_FILL: begin
            // flush remaining bits, padded with zeros up to the full data area
            if (dcnt_ff == DATA_BYTES) begin
               state_in = ST_FLAGS;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_byte = acc_ff[7:0];
               acc_in    = acc_ff >> 8;
               dcnt_in   = dcnt_ff + 1'b1;
            end
         end
         ST_FLAGS: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = FLAGS_BYTE;
               state_in  = ST_END;
            end
         end
         ST_END: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_byte   = end_marker;
               emit_eof    = 1'b1;
               state_in    = ST_RUN;
               acc_in      = '0;
               pend_in     = '0;
               dcnt_in     = '0;
               last_due_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.frame_byte   = emit_byte;
         rsp_payload_in.end_of_frame = emit_eof;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         acc_ff       <= '0;
         pend_ff      <= '0;
         dcnt_ff      <= '0;
         last_due_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         dcnt_ff      <= dcnt_in;
         last_due_ff  <= last_due_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/core/sbus_frame_encoder.sv @@
// Path: with the back part idle, a request's first byte is registered in the queue slot,
// then in the back part's bit store or state, then in the output register.
// Throughput: at most one frame byte per cycle, none while rsp_stall holds the output; a
// taken data request causes one or two bytes. The opening request adds the start byte, and
// the closing request adds the zero fill, flags and end bytes.
// Reset (synchronous): no frame open, bit store empty, queue empty, end marker zero.
module sbus_frame_encoder #(
   parameter int unsigned CHANNEL_COUNT = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sfe_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sfe_pkg::rsp_type rsp_payload,
   input  logic             csr_write,
   input  logic [7:0]       csr_data
);
   import sfe_pkg::*;

   logic [7:0] end_marker_q_ff, end_marker_q_in;
   logic       push, pop, q_full, q_valid;
   entry_type  push_entry, q_entry;

   assign end_marker_q_in = csr_write ? csr_data : end_marker_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_marker_q_ff <= '0;
      end else begin
         end_marker_q_ff <= end_marker_q_in;
      end
   end

   sfe_front #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   sfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .q_full    (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_entry   (q_entry)
   );

   sfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop),
      .end_marker (end_marker_q_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
